### hdl/tep_pkg.sv
// Shared types and constants for the tunnel effect pixel generator.
package tep_pkg;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_ROTATION_SPEED = 3'd2,
    REG_TRAVEL_SPEED   = 3'd3,
    REG_PALETTE_SPEED  = 3'd4,
    REG_BEAT_KICK      = 3'd5
  } cfg_reg_t;

  localparam int unsigned DEF_WIDTH  = 160;
  localparam int unsigned DEF_HEIGHT = 120;
  localparam int unsigned CORDIC_ITERS = 16;
  localparam int unsigned ZW = 18;

  // atan(2^-i) in 1/65536 turn
  function automatic logic [13:0] atan_turn(input int unsigned i);
    logic [13:0] r;
    case (i)
      0:  r = 14'd8192;
      1:  r = 14'd4836;
      2:  r = 14'd2555;
      3:  r = 14'd1297;
      4:  r = 14'd651;
      5:  r = 14'd326;
      6:  r = 14'd163;
      7:  r = 14'd81;
      8:  r = 14'd41;
      9:  r = 14'd20;
      10: r = 14'd10;
      11: r = 14'd5;
      12: r = 14'd3;
      13: r = 14'd1;
      14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/tunnel_effect_pixel_generator.sv
// Tunnel effect pixel generator: fully pipelined pixel path and frame phase state.
// Pixel path: (2*DW+14)-stage divider, then (DW+7)-stage square root; the 16-stage CORDIC runs beside them.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Frame ticks produce no result; they update the phases as they leave stage 1.
// Reset (rst, synchronous) clears valid bits and phases and loads register defaults.
module tunnel_effect_pixel_generator #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_x[9:0], pixel_y[19:10], elapsed_time[35:20], beat_hit[36]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pixel_value[7:0]
  output logic        m_tuser,   // coord_error
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DMAX = (MAX_DIM > 1024) ? MAX_DIM : 1024;
  localparam int DW   = $clog2(DMAX + 1);
  localparam int XW   = DW + 2;
  localparam int SW   = 2 * XW;
  localparam int TW   = 2 * DW + 14;
  localparam int HW   = TW / 2;
  localparam int RW   = HW + 2;
  localparam int CW   = DW + 20;
  localparam int NIT  = tep_pkg::CORDIC_ITERS;
  localparam int ZW   = tep_pkg::ZW;
  localparam int CE   = 2 + NIT;
  localparam int US   = CE + 1;
  localparam int DE   = 3 + TW;
  localparam int QS   = DE + HW;
  localparam int NS   = QS + 3;

  // configuration
  logic [10:0] frame_width, frame_height;
  logic [15:0] rotation_speed, travel_speed;
  logic [7:0]  palette_speed, beat_kick;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= 11'(tep_pkg::DEF_WIDTH);
      frame_height   <= 11'(tep_pkg::DEF_HEIGHT);
      rotation_speed <= '0;
      travel_speed   <= '0;
      palette_speed  <= '0;
      beat_kick      <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        tep_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data[10:0];
        tep_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data[10:0];
        tep_pkg::REG_ROTATION_SPEED: rotation_speed <= cfg_data;
        tep_pkg::REG_TRAVEL_SPEED:   travel_speed   <= cfg_data;
        tep_pkg::REG_PALETTE_SPEED:  palette_speed  <= cfg_data[7:0];
        tep_pkg::REG_BEAT_KICK:      beat_kick      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff, h_eff;
  always_comb begin
    if (frame_width == '0) w_eff = DW'(tep_pkg::DEF_WIDTH);
    else if (int'(frame_width) > MAX_DIM) w_eff = DW'(MAX_DIM);
    else w_eff = DW'(frame_width);
    if (frame_height == '0) h_eff = DW'(tep_pkg::DEF_HEIGHT);
    else if (int'(frame_height) > MAX_DIM) h_eff = DW'(MAX_DIM);
    else h_eff = DW'(frame_height);
  end

  logic adv;
  logic vld [1:NS];
  assign adv      = !vld[NS] || m_tready;
  assign s_tready = adv;

  // stage 1: capture
  logic [9:0]             in_x, in_y;
  logic [15:0]            in_el;
  logic signed [XW-1:0]   dx_in, dy_in;
  assign in_x  = s_tdata[9:0];
  assign in_y  = s_tdata[19:10];
  assign in_el = s_tdata[35:20];
  assign dx_in = $signed(XW'({in_x, 1'b0})) - $signed(XW'(w_eff)) + XW'(1);
  assign dy_in = $signed(XW'({in_y, 1'b0})) - $signed(XW'(h_eff)) + XW'(1);

  logic                 pix1, beat1, err1;
  logic signed [XW-1:0] dx1, dy1;
  logic [DW-1:0]        w1;
  logic signed [32:0]   prod_rot1, prod_trv1;

  always_ff @(posedge clk) begin
    if (rst) vld[1] <= 1'b0;
    else if (adv) vld[1] <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pix1      <= !s_tuser;
      beat1     <= s_tdata[36];
      err1      <= (DW'(in_x) >= w_eff) || (DW'(in_y) >= h_eff);
      dx1       <= dx_in;
      dy1       <= dy_in;
      w1        <= w_eff;
      prod_rot1 <= $signed(rotation_speed) * $signed({1'b0, in_el});
      prod_trv1 <= $signed(travel_speed) * $signed({1'b0, in_el});
    end
  end

  // frame phases
  logic [7:0] angle_phase, depth_phase, palette_shift;
  logic signed [33:0] rnd_rot, rnd_trv;
  logic tick_go;
  assign rnd_rot = 34'(prod_rot1) + 34'sd32768;
  assign rnd_trv = 34'(prod_trv1) + 34'sd32768;
  assign tick_go = adv && vld[1] && !pix1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_phase   <= '0;
      depth_phase   <= '0;
      palette_shift <= '0;
    end else if (tick_go) begin
      angle_phase   <= angle_phase + rnd_rot[23:16];
      depth_phase   <= depth_phase + rnd_trv[23:16];
      palette_shift <= palette_shift + palette_speed + (beat1 ? beat_kick : 8'd0);
    end
  end

  // carried fields
  logic       err [2:NS];
  logic       ctr [2:NS];
  logic [7:0] aph [2:NS];
  logic [7:0] dph [2:NS];
  logic [7:0] psh [2:NS];
  logic [7:0] uu  [US:QS+1];

  logic [SW-1:0]  sqx2, sqy2;
  logic [2*DW-1:0] ww2;

  // CORDIC
  logic signed [CW-1:0] cx [2:CE];
  logic signed [CW-1:0] cy [2:CE];
  logic signed [ZW-1:0] cz [2:CE];

  // divider and square root
  logic [SW-1:0] dvs [3:DE];
  logic [SW-1:0] drm [3:DE];
  logic [TW-1:0] dnd [3:DE];
  logic [TW-1:0] dqt [3:DE];
  logic [TW-1:0] sop [DE+1:QS];
  logic [RW-1:0] srm [DE+1:QS];
  logic [HW-1:0] srt [DE+1:QS];

  logic [7:0] vv, tex;

  always_ff @(posedge clk) begin
    if (rst) vld[2] <= 1'b0;
    else if (adv) vld[2] <= vld[1] && pix1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      err[2] <= err1;
      ctr[2] <= (dx1 == '0) && (dy1 == '0);
      aph[2] <= angle_phase;
      dph[2] <= depth_phase;
      psh[2] <= palette_shift;
      sqx2   <= $unsigned(SW'(dx1) * SW'(dx1));
      sqy2   <= $unsigned(SW'(dy1) * SW'(dy1));
      ww2    <= w1 * w1;
      if (dx1[XW-1]) begin
        cx[2] <= CW'(-dx1) <<< 16;
        cy[2] <= CW'(-dy1) <<< 16;
        cz[2] <= ZW'(32768);
      end else begin
        cx[2] <= CW'(dx1) <<< 16;
        cy[2] <= CW'(dy1) <<< 16;
        cz[2] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvs[3] <= sqx2 + sqy2;
      dnd[3] <= {ww2, 14'd0};
      drm[3] <= '0;
      dqt[3] <= '0;
    end
  end

  genvar k;
  for (k = 3; k <= NS; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (adv) vld[k] <= vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        err[k] <= err[k-1];
        ctr[k] <= ctr[k-1];
        aph[k] <= aph[k-1];
        dph[k] <= dph[k-1];
        psh[k] <= psh[k-1];
      end
    end
  end

  for (k = 0; k < NIT; k++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    assign xs = cx[2+k] >>> k;
    assign ys = cy[2+k] >>> k;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy[2+k][CW-1]) begin
          cx[3+k] <= cx[2+k] + ys;
          cy[3+k] <= cy[2+k] - xs;
          cz[3+k] <= cz[2+k] + ZW'(tep_pkg::atan_turn(k));
        end else begin
          cx[3+k] <= cx[2+k] - ys;
          cy[3+k] <= cy[2+k] + xs;
          cz[3+k] <= cz[2+k] - ZW'(tep_pkg::atan_turn(k));
        end
      end
    end
  end

  logic [ZW-1:0] zr;
  assign zr = cz[CE] + ZW'(32896);
  always_ff @(posedge clk) begin
    if (adv) uu[US] <= (ctr[CE] ? 8'd128 : zr[15:8]) + aph[CE];
  end
  for (k = US + 1; k <= QS + 1; k++) begin : g_ucarry
    always_ff @(posedge clk) begin
      if (adv) uu[k] <= uu[k-1];
    end
  end

  // restoring divide: one quotient bit per stage
  for (k = 0; k < TW; k++) begin : g_div
    logic [SW:0] trm;
    logic        ge;
    assign trm = {drm[3+k], dnd[3+k][TW-1]};
    assign ge  = trm >= {1'b0, dvs[3+k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dvs[4+k] <= dvs[3+k];
        dnd[4+k] <= dnd[3+k] << 1;
        drm[4+k] <= ge ? SW'(trm - {1'b0, dvs[3+k]}) : SW'(trm);
        dqt[4+k] <= {dqt[3+k][TW-2:0], ge};
      end
    end
  end

  // digit-by-digit square root: one root bit per stage
  for (k = 0; k < HW; k++) begin : g_sqrt
    logic [TW-1:0] op_in;
    logic [RW-1:0] rm_in;
    logic [HW-1:0] rt_in;
    logic [RW+1:0] trm;
    logic [RW+1:0] trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign op_in = dqt[DE];
      assign rm_in = '0;
      assign rt_in = '0;
    end else begin : g_rest
      assign op_in = sop[DE+k];
      assign rm_in = srm[DE+k];
      assign rt_in = srt[DE+k];
    end
    assign trm   = {rm_in, op_in[TW-1:TW-2]};
    assign trial = (RW+2)'({rt_in, 2'b01});
    assign ge    = trm >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sop[DE+k+1] <= op_in << 2;
        srm[DE+k+1] <= ge ? RW'(trm - trial) : RW'(trm);
        srt[DE+k+1] <= {rt_in[HW-2:0], ge};
      end
    end
  end

  // v and texel
  logic [HW:0] nn;
  assign nn = ({1'b0, srt[QS]} + (HW+1)'(1)) >> 1;
  always_ff @(posedge clk) begin
    if (adv) vv <= (ctr[QS] ? 8'd0 : nn[7:0]) + dph[QS];
  end

  logic       chk;
  logic [7:0] stripes, base;
  logic [8:0] tsum;
  assign chk     = uu[QS+1][5] ^ vv[5];
  assign stripes = (uu[QS+1] * 8'd5) + (vv * 8'd3);
  assign base    = chk ? stripes : 8'd255 - stripes;
  assign tsum    = {1'b0, base} + ((vv[4:0] < 5'd2) ? 9'd64 : 9'd0);
  always_ff @(posedge clk) begin
    if (adv) tex <= tsum[8] ? 8'd255 : tsum[7:0];
  end

  logic [7:0] pval;
  always_ff @(posedge clk) begin
    if (adv) pval <= err[NS-1] ? 8'd0 : tex + psh[NS-1];
  end

  assign m_tvalid = vld[NS];
  assign m_tdata  = pval;
  assign m_tuser  = err[NS];

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("flagged pixel with nonzero value");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !tick_go |=> $stable(angle_phase) && $stable(depth_phase) && $stable(palette_shift))
    else $error("phase changed without a frame tick");

  a_tick_no_result: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> !vld[2])
    else $error("frame tick entered the pixel path");

endmodule
